// ===== design/xorshift64star_random_stream_assert.svh =====
// Assertion macros used by the xorshift64* random stream checker.
`ifndef XORSHIFT64STAR_RANDOM_STREAM_ASSERT_SVH
`define XORSHIFT64STAR_RANDOM_STREAM_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define XS64S_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("xs64s check failed");

// The consequent must hold in the cycle after the antecedent.
`define XS64S_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("xs64s check failed");

`endif

// ===== design/xs64s_pkg.sv =====
// Types, constants and helper functions of the xorshift64* random stream.
package xs64s_pkg;

    localparam int WORD_W     = 64;
    localparam int HALF_W     = WORD_W / 2;
    localparam int BOUND_W    = 32;
    localparam int SPAN_W     = BOUND_W + 1;
    localparam int FRAC_SHIFT = 11;
    localparam int FRAC_W     = WORD_W - FRAC_SHIFT;
    localparam int CMD_W      = 2;
    localparam int REM_CNT_W  = $clog2(WORD_W);

    localparam logic [WORD_W-1:0] SEED_MIX = 64'h9E37_79B9_7F4A_7C15;
    localparam logic [WORD_W-1:0] OUT_MULT = 64'h2545_F491_4F6C_DD1D;

    localparam int SHIFT_R1 = 12;
    localparam int SHIFT_L  = 25;
    localparam int SHIFT_R2 = 27;

    localparam logic [CMD_W-1:0] CMD_RESEED = 2'd0;
    localparam logic [CMD_W-1:0] CMD_NEXT   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RANGE  = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0]          command;
        logic signed [WORD_W-1:0]  seed;
        logic signed [BOUND_W-1:0] range_low;
        logic signed [BOUND_W-1:0] range_high;
    } req_payload_t;

    typedef struct packed {
        logic [FRAC_W-1:0]         fraction_bits;
        logic signed [BOUND_W-1:0] range_value;
        logic                      is_range;
    } rsp_payload_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_REM,
        ST_DONE
    } state_t;

    // A mixed seed of zero would lock the generator, so it is replaced.
    function automatic logic [WORD_W-1:0] mix_seed(input logic [WORD_W-1:0] seed);
        logic [WORD_W-1:0] m;
        begin
            m = seed ^ SEED_MIX;
            mix_seed = (m != '0) ? m : OUT_MULT;
        end
    endfunction

    function automatic logic [WORD_W-1:0] xorshift(input logic [WORD_W-1:0] s_in);
        logic [WORD_W-1:0] s;
        begin
            s = s_in;
            s = s ^ (s >> SHIFT_R1);
            s = s ^ (s << SHIFT_L);
            s = s ^ (s >> SHIFT_R2);
            xorshift = s;
        end
    endfunction

endpackage

// ===== design/xs64s_stream_if.sv =====
// Valid/ready stream channel carrying one payload item per handshake.
interface xs64s_stream_if #(
    parameter type payload_t = logic
) ();
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ===== design/xs64s_mul.sv =====
// Low 64 bits of operand times the output constant, one 32x32 product per cycle.
module xs64s_mul (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [xs64s_pkg::WORD_W-1:0] operand,
    output logic                         done,
    output logic [xs64s_pkg::WORD_W-1:0] product
);
    import xs64s_pkg::*;

    localparam logic [1:0] STEP_LOW     = 2'd0;
    localparam logic [1:0] STEP_CROSS_A = 2'd1;
    localparam logic [1:0] STEP_CROSS_B = 2'd2;

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [1:0]        step_reg, step_next;
    logic [WORD_W-1:0] a_reg, a_next;
    logic [WORD_W-1:0] acc_reg, acc_next;

    logic [HALF_W-1:0] a_half;
    logic [HALF_W-1:0] b_half;
    logic [WORD_W-1:0] partial;
    logic [WORD_W-1:0] term;

    // Cross products only reach the upper half of the 64-bit result.
    assign a_half  = (step_reg == STEP_CROSS_A) ? a_reg[WORD_W-1:HALF_W] : a_reg[HALF_W-1:0];
    assign b_half  = (step_reg == STEP_CROSS_B) ? OUT_MULT[WORD_W-1:HALF_W]
                                                : OUT_MULT[HALF_W-1:0];
    assign partial = WORD_W'(a_half) * WORD_W'(b_half);
    assign term    = (step_reg == STEP_LOW) ? partial
                                            : {partial[HALF_W-1:0], {HALF_W{1'b0}}};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        a_next    = a_reg;
        acc_next  = acc_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = STEP_LOW;
            a_next    = operand;
            acc_next  = '0;
        end
        else if (busy_reg)
        begin
            acc_next  = acc_reg + term;
            step_next = step_reg + 2'd1;
            if (step_reg == STEP_CROSS_B)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= STEP_LOW;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        acc_reg <= acc_next;
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

// ===== design/xs64s_rem.sv =====
// Restoring remainder unit: 64-bit dividend by a span of up to 2^32, one bit per cycle.
module xs64s_rem (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [xs64s_pkg::WORD_W-1:0] dividend,
    input  logic [xs64s_pkg::SPAN_W-1:0] divisor,
    output logic                         done,
    output logic [xs64s_pkg::SPAN_W-1:0] remainder
);
    import xs64s_pkg::*;

    localparam logic [REM_CNT_W-1:0] LAST_STEP = REM_CNT_W'(WORD_W - 1);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [REM_CNT_W-1:0] count_reg, count_next;
    logic [WORD_W-1:0]    dvd_reg, dvd_next;
    logic [SPAN_W-1:0]    dvs_reg, dvs_next;
    logic [SPAN_W-1:0]    rem_reg, rem_next;

    logic [SPAN_W:0]      trial;
    logic [SPAN_W:0]      diff;
    logic                 fits;

    // The running remainder stays below the divisor, so 33 bits hold it.
    assign trial = {rem_reg, dvd_reg[WORD_W-1]};
    assign fits  = (trial >= {1'b0, dvs_reg});
    assign diff  = trial - {1'b0, dvs_reg};

    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        count_next = count_reg;
        dvd_next   = dvd_reg;
        dvs_next   = dvs_reg;
        rem_next   = rem_reg;
        if (start)
        begin
            busy_next  = 1'b1;
            count_next = '0;
            dvd_next   = dividend;
            dvs_next   = divisor;
            rem_next   = '0;
        end
        else if (busy_reg)
        begin
            rem_next   = fits ? diff[SPAN_W-1:0] : trial[SPAN_W-1:0];
            dvd_next   = {dvd_reg[WORD_W-2:0], 1'b0};
            count_next = count_reg + REM_CNT_W'(1);
            if (count_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

// ===== design/xorshift64star_random_stream.sv =====
// Top level of the xorshift64* random stream: command sequencer and generator state.
//
// Items arrive on req (command, seed, range_low, range_high) and results leave on
// rsp (fraction_bits, range_value, is_range); both are valid/ready channels.
// A reseed item is absorbed in its accept cycle and gives no result; req stays
// ready. A next item advances the state, then one shared 32x32 multiplier builds
// the 64-bit output product in its low, cross A and cross B steps; the result
// then passes the DONE state into the output register. A range item with a real
// span adds the remainder unit, which takes one dividend bit per cycle through
// all 64 bits. A range item whose high bound is not above its low bound returns
// the low bound through the DONE state without touching the generator state.
// Command code 3 is accepted and dropped. One item is in work at a time; req is
// ready again once the result sits in the output register, so the next item
// may start while that result waits. If the receiver stalls with the output
// register still full, the finished result waits inside and req stays low.
// Reset puts the state at the value seeded with zero and empties the output.
module xorshift64star_random_stream (
    input logic              clk,
    input logic              rst_n,
    xs64s_stream_if.sink     req,
    xs64s_stream_if.source   rsp
);
    import xs64s_pkg::*;

    state_t               state_reg, state_next;
    logic [WORD_W-1:0]    gen_reg, gen_next;
    logic                 is_range_reg, is_range_next;
    logic                 empty_reg, empty_next;
    logic [BOUND_W-1:0]   lo_reg, lo_next;
    logic [SPAN_W-1:0]    span_reg, span_next;
    logic                 out_valid_reg, out_valid_next;
    rsp_payload_t         out_reg, out_next;

    logic                 accept;
    logic                 out_load;
    logic                 mul_start;
    logic                 rem_start;
    logic                 mul_done;
    logic                 rem_done;
    logic [WORD_W-1:0]    product;
    logic [SPAN_W-1:0]    remainder;
    logic [WORD_W-1:0]    advanced;
    logic [BOUND_W-1:0]   lo_biased;
    logic [BOUND_W-1:0]   hi_biased;
    logic                 span_ok;

    assign accept    = req.valid && req.ready;
    assign advanced  = xorshift(gen_reg);
    // Flipping the sign bit makes signed bounds compare and subtract as unsigned.
    assign lo_biased = {~req.payload.range_low[BOUND_W-1], req.payload.range_low[BOUND_W-2:0]};
    assign hi_biased = {~req.payload.range_high[BOUND_W-1],
                        req.payload.range_high[BOUND_W-2:0]};
    assign span_ok   = (hi_biased > lo_biased);

    xs64s_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .operand (advanced),
        .done    (mul_done),
        .product (product)
    );

    xs64s_rem u_rem (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (rem_start),
        .dividend  (product),
        .divisor   (span_reg),
        .done      (rem_done),
        .remainder (remainder)
    );

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (req.payload.command == CMD_NEXT)
                    begin
                        state_next = ST_MUL;
                    end
                    else if (req.payload.command == CMD_RANGE)
                    begin
                        state_next = span_ok ? ST_MUL : ST_DONE;
                    end
                end
            end
            ST_MUL:
            begin
                if (mul_done)
                begin
                    state_next = is_range_reg ? ST_REM : ST_DONE;
                end
            end
            ST_REM:
            begin
                if (rem_done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs.
    always_comb
    begin
        req.ready = 1'b0;
        mul_start = 1'b0;
        rem_start = 1'b0;
        out_load  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                req.ready = 1'b1;
                if (req.valid)
                begin
                    mul_start = (req.payload.command == CMD_NEXT) ||
                                ((req.payload.command == CMD_RANGE) && span_ok);
                end
            end
            ST_MUL:
            begin
                rem_start = mul_done && is_range_reg;
            end
            ST_REM:
            begin
                rem_start = 1'b0;
            end
            ST_DONE:
            begin
                out_load = !out_valid_reg || rsp.ready;
            end
            default:
            begin
                req.ready = 1'b0;
            end
        endcase
    end

    // Datapath registers.
    always_comb
    begin
        gen_next       = gen_reg;
        is_range_next  = is_range_reg;
        empty_next     = empty_reg;
        lo_next        = lo_reg;
        span_next      = span_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;

        if (accept)
        begin
            lo_next       = req.payload.range_low;
            span_next     = {1'b0, hi_biased} - {1'b0, lo_biased} + SPAN_W'(1);
            is_range_next = (req.payload.command == CMD_RANGE);
            empty_next    = !span_ok;
            if (req.payload.command == CMD_RESEED)
            begin
                gen_next = mix_seed(req.payload.seed);
            end
            else if (mul_start)
            begin
                gen_next = advanced;
            end
        end

        if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (out_load)
        begin
            out_valid_next = 1'b1;
            if (is_range_reg)
            begin
                out_next.fraction_bits = '0;
                out_next.range_value   = empty_reg ? lo_reg : lo_reg + remainder[BOUND_W-1:0];
                out_next.is_range      = 1'b1;
            end
            else
            begin
                out_next.fraction_bits = product[WORD_W-1:FRAC_SHIFT];
                out_next.range_value   = '0;
                out_next.is_range      = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            gen_reg       <= mix_seed('0);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            gen_reg       <= gen_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        is_range_reg <= is_range_next;
        empty_reg    <= empty_next;
        lo_reg       <= lo_next;
        span_reg     <= span_next;
        out_reg      <= out_next;
    end

    assign rsp.valid   = out_valid_reg;
    assign rsp.payload = out_reg;

endmodule

// ===== design/xs64s_checker.sv =====
// Port-level checks of the xorshift64* random stream, bound to its top level.
`include "xorshift64star_random_stream_assert.svh"

module xs64s_checker (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 req_valid,
    input logic                                 req_ready,
    input logic [xs64s_pkg::CMD_W-1:0]          req_command,
    input logic                                 rsp_valid,
    input logic                                 rsp_ready,
    input logic [xs64s_pkg::FRAC_W-1:0]         rsp_fraction_bits,
    input logic signed [xs64s_pkg::BOUND_W-1:0] rsp_range_value,
    input logic                                 rsp_is_range
);
    import xs64s_pkg::*;

    // A reseed item finishes in its accept cycle, so the block stays open.
    `XS64S_ASSERT_NEXT(reseed_keeps_ready, clk, rst_n, req_valid && req_ready && (req_command == CMD_RESEED), req_ready)

    // A next item occupies the multiplier, so no item follows directly.
    `XS64S_ASSERT_NEXT(next_blocks_input, clk, rst_n, req_valid && req_ready && (req_command == CMD_NEXT), !req_ready)

    // Only the field of the answered command carries a value.
    `XS64S_ASSERT_SAME(unused_field_zero, clk, rst_n, rsp_valid, rsp_is_range ? (rsp_fraction_bits == '0) : (rsp_range_value == '0))

    // A stalled item holds its place and its bits.
    `XS64S_ASSERT_NEXT(stalled_item_held, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_fraction_bits) && $stable(rsp_range_value) && $stable(rsp_is_range))

endmodule

bind xorshift64star_random_stream xs64s_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .req_valid         (req.valid),
    .req_ready         (req.ready),
    .req_command       (req.payload.command),
    .rsp_valid         (rsp.valid),
    .rsp_ready         (rsp.ready),
    .rsp_fraction_bits (rsp.payload.fraction_bits),
    .rsp_range_value   (rsp.payload.range_value),
    .rsp_is_range      (rsp.payload.is_range)
);

// ===== tb/tb_top.sv =====
// Self-checking testbench for the xorshift64* random stream block.
`timescale 1ns / 100ps

module tb_top;
    import xs64s_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int RESET_CYCLES  = 7;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 100;
    localparam int IDLE_LIMIT    = 2000;
    localparam int RANDOM_ITEMS  = 1500;
    localparam int REPORT_MAX    = 10;

    logic clk = 1'b0;
    logic rst_n;

    xs64s_stream_if #(.payload_t(req_payload_t)) req_if ();
    xs64s_stream_if #(.payload_t(rsp_payload_t)) rsp_if ();

    xorshift64star_random_stream uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    always #5 clk = ~clk;

    logic [WORD_W-1:0] gen_state;
    rsp_payload_t      pending_draws[$];
    int                error_count = 0;
    int                idle_cycles = 0;
    bit                no_gaps = 1'b0;
    bit                hold_request = 1'b0;

    // Mostly short gaps, now and then a long one.
    function automatic int draw_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 80);
    endfunction

    function automatic logic [WORD_W-1:0] reseed_value(input logic [WORD_W-1:0] seed);
        logic [WORD_W-1:0] mixed;
        mixed = seed ^ SEED_MIX;
        return (mixed == '0) ? OUT_MULT : mixed;
    endfunction

    // Steps the generator and returns the full 64-bit output product.
    function automatic logic [WORD_W-1:0] advance_state();
        logic [WORD_W-1:0] s;
        s = gen_state;
        s = s ^ (s >> SHIFT_R1);
        s = s ^ (s << SHIFT_L);
        s = s ^ (s >> SHIFT_R2);
        gen_state = s;
        return s * OUT_MULT;
    endfunction

    function automatic void predict_draw(input req_payload_t item);
        rsp_payload_t      draw;
        logic [WORD_W-1:0] product;
        logic [WORD_W-1:0] lo_biased;
        logic [WORD_W-1:0] hi_biased;
        logic [WORD_W-1:0] offset;
        draw = '0;
        case (item.command)
            CMD_RESEED:
                gen_state = reseed_value(item.seed);
            CMD_NEXT:
            begin
                product = advance_state();
                draw.fraction_bits = product[WORD_W-1:FRAC_SHIFT];
                pending_draws.push_back(draw);
            end
            CMD_RANGE:
            begin
                // Flipping the sign bit lets the bounds compare as unsigned values.
                lo_biased = {32'd0, item.range_low} ^ 64'h8000_0000;
                hi_biased = {32'd0, item.range_high} ^ 64'h8000_0000;
                if (hi_biased <= lo_biased)
                begin
                    draw.range_value = item.range_low;
                end
                else
                begin
                    offset = advance_state() % (hi_biased - lo_biased + 64'd1);
                    draw.range_value = item.range_low + offset[BOUND_W-1:0];
                end
                draw.is_range = 1'b1;
                pending_draws.push_back(draw);
            end
            default:
            begin
            end
        endcase
    endfunction

    function automatic void note_error();
        error_count++;
    endfunction

    // Results are checked before new items are predicted, so a draw never meets its own item.
    always @(posedge clk)
    begin
        rsp_payload_t want;
        rsp_payload_t got;
        if (!rst_n)
        begin
            gen_state = reseed_value('0);
        end
        else
        begin
            if (rsp_if.valid && rsp_if.ready)
            begin
                got = rsp_if.payload;
                if (pending_draws.size() == 0)
                begin
                    note_error();
                    if (error_count <= REPORT_MAX)
                        $display("%0t: unexpected result frac=%h value=%0d range=%b",
                                 $realtime, got.fraction_bits, got.range_value, got.is_range);
                end
                else
                begin
                    want = pending_draws.pop_front();
                    if (got.fraction_bits !== want.fraction_bits
                        || got.range_value !== want.range_value
                        || got.is_range !== want.is_range)
                    begin
                        note_error();
                        if (error_count <= REPORT_MAX)
                            $display("%0t: mismatch frac=%h/%h value=%0d/%0d range=%b/%b",
                                     $realtime, got.fraction_bits, want.fraction_bits,
                                     got.range_value, want.range_value,
                                     got.is_range, want.is_range);
                    end
                end
            end
            if (req_if.valid && req_if.ready)
                predict_draw(req_if.payload);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("xorshift64star_random_stream test failed");
                $finish;
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off when a test asks for it.
    initial
    begin
        int stall_left;
        stall_left = 0;
        rsp_if.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                stall_left = HOLD_CYCLES;
            end
            else if (stall_left == 0)
            begin
                stall_left = draw_gap();
            end
            if (stall_left > 0)
            begin
                rsp_if.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                rsp_if.ready <= 1'b1;
            end
        end
    end

    function automatic req_payload_t make_item(input logic [CMD_W-1:0] cmd,
                                               input logic [WORD_W-1:0] seed,
                                               input logic [BOUND_W-1:0] lo,
                                               input logic [BOUND_W-1:0] hi);
        req_payload_t item;
        item.command    = cmd;
        item.seed       = seed;
        item.range_low  = lo;
        item.range_high = hi;
        return item;
    endfunction

    function automatic logic [WORD_W-1:0] rand_word();
        return {$urandom(), $urandom()};
    endfunction

    // Valid stays high from one item to the next unless a gap is drawn.
    task automatic send_item(input req_payload_t item);
        int gap;
        gap = draw_gap();
        if (gap > 0)
        begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_if.valid   <= 1'b1;
        req_if.payload <= item;
        @(posedge clk);
        while (!req_if.ready)
            @(posedge clk);
    endtask

    task automatic finish_phase();
        req_if.valid <= 1'b0;
        @(posedge clk);
        while (pending_draws.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_after_reset();
        send_item(make_item(CMD_NEXT, rand_word(), $urandom(), $urandom()));
        send_item(make_item(CMD_NEXT, rand_word(), $urandom(), $urandom()));
        send_item(make_item(CMD_RANGE, rand_word(), -32'sd1000, 32'sd1000));
        finish_phase();
    endtask

    task automatic test_reseed();
        logic [WORD_W-1:0] seeds[5];
        seeds[0] = '0;
        seeds[1] = SEED_MIX;
        seeds[2] = '1;
        seeds[3] = 64'h8000_0000_0000_0000;
        seeds[4] = 64'h7FFF_FFFF_FFFF_FFFF;
        foreach (seeds[i])
        begin
            send_item(make_item(CMD_RESEED, seeds[i], $urandom(), $urandom()));
            send_item(make_item(CMD_NEXT, rand_word(), $urandom(), $urandom()));
        end
        finish_phase();
    endtask

    task automatic test_range_bounds();
        send_item(make_item(CMD_RANGE, rand_word(), 32'sd77, 32'sd77));
        send_item(make_item(CMD_RANGE, rand_word(), 32'sd5, -32'sd5));
        send_item(make_item(CMD_RANGE, rand_word(), 32'h7FFF_FFFF, 32'h8000_0000));
        send_item(make_item(CMD_RANGE, rand_word(), 32'h8000_0000, 32'h7FFF_FFFF));
        send_item(make_item(CMD_RANGE, rand_word(), 32'h7FFF_FFFE, 32'h7FFF_FFFF));
        send_item(make_item(CMD_RANGE, rand_word(), 32'h8000_0000, 32'h8000_0001));
        finish_phase();
    endtask

    task automatic test_unused_command();
        send_item(make_item(CMD_UNUSED, rand_word(), $urandom(), $urandom()));
        send_item(make_item(CMD_NEXT, rand_word(), $urandom(), $urandom()));
        finish_phase();
    endtask

    function automatic req_payload_t random_item();
        logic [BOUND_W-1:0] lo;
        logic [BOUND_W-1:0] hi;
        int                 pick;
        int                 shape;
        pick = $urandom_range(0, 99);
        if (pick < 10)
        begin
            if ($urandom_range(0, 49) == 0)
                return make_item(CMD_RESEED, SEED_MIX, $urandom(), $urandom());
            return make_item(CMD_RESEED, rand_word(), $urandom(), $urandom());
        end
        if (pick < 45)
            return make_item(CMD_NEXT, rand_word(), $urandom(), $urandom());
        if (pick < 95)
        begin
            lo = $urandom();
            shape = $urandom_range(0, 99);
            if (shape < 40)
                hi = $urandom();
            else if (shape < 70)
                hi = lo + $urandom_range(1, 15);
            else if (shape < 80)
                hi = lo - $urandom_range(0, 3);
            else if (shape < 90)
            begin
                lo = 32'h8000_0000 + $urandom_range(0, 3);
                hi = 32'h7FFF_FFFF - $urandom_range(0, 3);
            end
            else
            begin
                lo = 32'h8000_0000;
                hi = 32'h7FFF_FFFF;
            end
            return make_item(CMD_RANGE, rand_word(), lo, hi);
        end
        return make_item(CMD_UNUSED, rand_word(), $urandom(), $urandom());
    endfunction

    task automatic test_back_to_back();
        no_gaps = 1'b1;
        repeat (100)
            send_item(random_item());
        finish_phase();
        no_gaps = 1'b0;
    endtask

    // The receiver holds off while items keep coming, so the block must stall its input.
    task automatic test_output_stall();
        hold_request = 1'b1;
        no_gaps = 1'b1;
        repeat (3)
            send_item(make_item(CMD_NEXT, rand_word(), $urandom(), $urandom()));
        send_item(make_item(CMD_RANGE, rand_word(), -32'sd50, 32'sd50));
        repeat (2)
            send_item(make_item(CMD_NEXT, rand_word(), $urandom(), $urandom()));
        finish_phase();
        no_gaps = 1'b0;
    endtask

    task automatic test_random_stream();
        repeat (RANDOM_ITEMS)
            send_item(random_item());
        finish_phase();
    endtask

    initial
    begin
        rst_n          <= 1'b0;
        req_if.valid   <= 1'b0;
        req_if.payload <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_after_reset();
        test_reseed();
        test_range_bounds();
        test_unused_command();
        test_back_to_back();
        test_output_stall();
        test_random_stream();

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (pending_draws.size() != 0)
            note_error();
        if (error_count == 0)
            $display("xorshift64star_random_stream test passed");
        else
            $display("xorshift64star_random_stream test failed");
        $finish;
    end

endmodule
